### rtl/core/sc1kd_pkg.sv
// ---------------------------------------------------------------------------
// sc1kd_pkg: shared types and constants of the set 1 key decoder
// Key codes, item kinds, result layout and the scan code character table.
// ---------------------------------------------------------------------------
`default_nettype none

package sc1kd_pkg;

  localparam int KEY_W     = 7;
  localparam int KEY_COUNT = 128;
  localparam int CAP_W     = 5;
  localparam int CODE_W    = 8;
  localparam int OUT_W     = 36;
  localparam int TDATA_W   = 40;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

  // item kinds carried on the input tuser bit
  localparam logic KIND_SCAN  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // key codes with low seven bits, release bit stripped
  localparam logic [KEY_W-1:0] KEY_FIRST_TEXT = 7'h02;
  localparam logic [KEY_W-1:0] KEY_CTRL       = 7'h1D;
  localparam logic [KEY_W-1:0] KEY_LSHIFT     = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT     = 7'h36;
  localparam logic [KEY_W-1:0] KEY_ALT        = 7'h38;
  localparam logic [KEY_W-1:0] KEY_TABLE_END  = 7'h3A;

  typedef struct packed {
    logic             alt;
    logic             ctrl;
    logic             shift;
    logic [CAP_W-1:0] count;
  } kstate_t;

  // packed from the top bit down, so code_echo lands in the low byte
  typedef struct packed {
    logic              alt_on;
    logic              ctrl_on;
    logic              shift_on;
    logic [7:0]        text_position;
    logic              text_valid;
    logic [CAP_W-1:0]  event_count;
    logic              event_stored;
    logic              key_state;
    logic              is_release;
    logic [7:0]        character;
    logic [CODE_W-1:0] code_echo;
  } result_t;

  function automatic logic is_text_key(input logic [KEY_W-1:0] key);
    logic ok;
    ok = (key >= KEY_FIRST_TEXT) && (key < KEY_TABLE_END) &&
         (key != KEY_CTRL) && (key != KEY_LSHIFT) &&
         (key != KEY_RSHIFT) && (key != KEY_ALT);
    return ok;
  endfunction

  // {shifted, plain} character pair per key; codes past the table give 0
  function automatic logic [7:0] char_lookup(input logic [KEY_W-1:0] key,
                                             input logic shift);
    logic [15:0] pair;
    case (key)
      7'h01: pair = {8'h1B, 8'h1B};
      7'h02: pair = {8'h21, 8'h31};
      7'h03: pair = {8'h40, 8'h32};
      7'h04: pair = {8'h23, 8'h33};
      7'h05: pair = {8'h24, 8'h34};
      7'h06: pair = {8'h25, 8'h35};
      7'h07: pair = {8'h5E, 8'h36};
      7'h08: pair = {8'h26, 8'h37};
      7'h09: pair = {8'h2A, 8'h38};
      7'h0A: pair = {8'h28, 8'h39};
      7'h0B: pair = {8'h29, 8'h30};
      7'h0C: pair = {8'h5F, 8'h2D};
      7'h0D: pair = {8'h2B, 8'h3D};
      7'h0E: pair = {8'h08, 8'h08};
      7'h0F: pair = {8'h09, 8'h09};
      7'h10: pair = {8'h51, 8'h71};
      7'h11: pair = {8'h57, 8'h77};
      7'h12: pair = {8'h45, 8'h65};
      7'h13: pair = {8'h52, 8'h72};
      7'h14: pair = {8'h54, 8'h74};
      7'h15: pair = {8'h59, 8'h79};
      7'h16: pair = {8'h55, 8'h75};
      7'h17: pair = {8'h49, 8'h69};
      7'h18: pair = {8'h4F, 8'h6F};
      7'h19: pair = {8'h50, 8'h70};
      7'h1A: pair = {8'h7B, 8'h5B};
      7'h1B: pair = {8'h7D, 8'h5D};
      7'h1C: pair = {8'h0A, 8'h0A};
      7'h1E: pair = {8'h41, 8'h61};
      7'h1F: pair = {8'h53, 8'h73};
      7'h20: pair = {8'h44, 8'h64};
      7'h21: pair = {8'h46, 8'h66};
      7'h22: pair = {8'h47, 8'h67};
      7'h23: pair = {8'h48, 8'h68};
      7'h24: pair = {8'h4A, 8'h6A};
      7'h25: pair = {8'h4B, 8'h6B};
      7'h26: pair = {8'h4C, 8'h6C};
      7'h27: pair = {8'h3A, 8'h3B};
      7'h28: pair = {8'h22, 8'h27};
      7'h29: pair = {8'h7E, 8'h60};
      7'h2B: pair = {8'h7C, 8'h5C};
      7'h2C: pair = {8'h5A, 8'h7A};
      7'h2D: pair = {8'h58, 8'h78};
      7'h2E: pair = {8'h43, 8'h63};
      7'h2F: pair = {8'h56, 8'h76};
      7'h30: pair = {8'h42, 8'h62};
      7'h31: pair = {8'h4E, 8'h6E};
      7'h32: pair = {8'h4D, 8'h6D};
      7'h33: pair = {8'h3C, 8'h2C};
      7'h34: pair = {8'h3E, 8'h2E};
      7'h35: pair = {8'h3F, 8'h2F};
      7'h37: pair = {8'h2A, 8'h2A};
      7'h39: pair = {8'h20, 8'h20};
      default: pair = 16'h0000;
    endcase
    return shift ? pair[15:8] : pair[7:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/sc1kd_ram.sv
// ---------------------------------------------------------------------------
// sc1kd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sc1kd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/sc1kd_decode.sv
// ---------------------------------------------------------------------------
// sc1kd_decode: single-pass decode of one staged item
// Builds the result and the next modifier, counter and text slot values.
// ---------------------------------------------------------------------------
`default_nettype none

module sc1kd_decode #(
  parameter int SLOT_W = 8
) (
  input  logic                           kind,
  input  logic [sc1kd_pkg::CODE_W-1:0]   scancode,
  input  logic                           key_bit_old,
  input  sc1kd_pkg::kstate_t             cur,
  input  logic [sc1kd_pkg::CAP_W-1:0]    capacity,
  input  logic [SLOT_W-1:0]              slot,
  input  logic [SLOT_W-1:0]              slot_last,
  output sc1kd_pkg::result_t             res,
  output sc1kd_pkg::kstate_t             nxt,
  output logic [SLOT_W-1:0]              slot_next,
  output logic                           key_wr,
  output logic                           key_bit_new
);
  import sc1kd_pkg::*;

  logic [KEY_W-1:0]    key;
  logic                rel;
  logic [SLOT_W+7:0]   slot_ext;

  assign key         = scancode[KEY_W-1:0];
  assign rel         = scancode[CODE_W-1];
  assign key_bit_new = ~key_bit_old;
  assign slot_ext    = {8'd0, slot};

  always_comb begin
    nxt       = cur;
    slot_next = slot;
    res       = '0;
    key_wr    = 1'b0;
    if (kind == KIND_CLEAR) begin
      nxt.count = '0;
    end else begin
      key_wr         = 1'b1;
      res.code_echo  = scancode;
      res.is_release = rel;
      res.key_state  = key_bit_new;
      // character uses shift as it stood before this byte
      res.character  = char_lookup(key, cur.shift);
      if (cur.count < capacity) begin
        nxt.count        = cur.count + 5'd1;
        res.event_stored = 1'b1;
      end
      if ((key == KEY_LSHIFT) || (key == KEY_RSHIFT)) begin
        nxt.shift = ~cur.shift;
      end else if (key == KEY_CTRL) begin
        nxt.ctrl = ~cur.ctrl;
      end else if (key == KEY_ALT) begin
        nxt.alt = ~cur.alt;
      end else if (!rel && is_text_key(key)) begin
        res.text_valid    = 1'b1;
        res.text_position = slot_ext[7:0];
        slot_next         = (slot == slot_last) ? '0 : slot + SLOT_W'(1);
      end
    end
    res.event_count = nxt.count;
    res.shift_on    = nxt.shift;
    res.ctrl_on     = nxt.ctrl;
    res.alt_on      = nxt.alt;
  end

endmodule

`default_nettype wire

### rtl/core/scancode_set1_key_decoder_core.sv
// ---------------------------------------------------------------------------
// scancode_set1_key_decoder_core: scan code set 1 key decoder
// Decodes set 1 bytes into characters, key state, modifier flags, an event
// count and a wrapping text position, one transaction per cycle while m_axis does not stall.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: scancode; tuser: kind
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: packed result, 40 bits
//  cfg       in   cfg_wr_en                      cfg_wr_data: event_capacity
//
//  One transaction per cycle sustained while m_axis takes results; the key
//  RAM read and the decode stage load when an input is taken, and the
//  decoded result registers onto m_axis when the decode stage advances.
//  The pace is set by the read-modify-write of the key state RAM, which
//  forwards the bit of the preceding transaction on a same-key collision.
//  Reset (rst, synchronous) empties both stages, clears modifiers, event
//  count, text slot and the key valid bits, and loads capacity with 10.
//  A stall on m_axis holds the decode stage; s_axis keeps taking a
//  transaction as long as the decode stage is empty or can move on in that cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module scancode_set1_key_decoder_core #(
  parameter int TEXT_RING_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] scancode
  input  logic                            s_axis_tuser,  // [0] kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] code_echo, [15:8] character, [16] is_release, [17] key_state,
  // [18] event_stored, [23:19] event_count, [24] text_valid,
  // [32:25] text_position, [33] shift_on, [34] ctrl_on, [35] alt_on
  output logic [sc1kd_pkg::TDATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_wr_en,
  input  logic [sc1kd_pkg::CAP_W-1:0]     cfg_wr_data   // event_capacity
);
  import sc1kd_pkg::*;

  localparam int SLOT_W = $clog2(TEXT_RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TEXT_RING_DEPTH - 1);

  // configuration and architectural state
  logic [CAP_W-1:0]     capacity;
  kstate_t              kstate;
  logic [SLOT_W-1:0]    text_slot;
  logic [KEY_COUNT-1:0] key_valid;

  // decode stage
  logic                 s1_valid;
  logic                 s1_kind;
  logic [CODE_W-1:0]    s1_code;
  logic                 fwd_hit;
  logic                 fwd_val;

  logic                 s_accept;
  logic                 s1_advance;
  logic                 ram_rd_data;
  logic                 key_bit_old;
  logic                 key_wr;
  logic                 key_bit_new;
  result_t              res;
  kstate_t              kstate_next;
  logic [SLOT_W-1:0]    text_slot_next;

  // the decode stage moves on whenever the output register is free or taken
  assign s1_advance    = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Entry never written reads as zero; a same-key write in the accept
  // cycle is not seen by the RAM read, so take the forwarded bit instead.
  assign key_bit_old = fwd_hit ? fwd_val : (key_valid[s1_code[KEY_W-1:0]] & ram_rd_data);

  sc1kd_ram #(
    .WIDTH (1),
    .DEPTH (KEY_COUNT)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (s1_advance && key_wr),
    .wr_addr (s1_code[KEY_W-1:0]),
    .wr_data (key_bit_new),
    .rd_en   (s_accept),
    .rd_addr (s_axis_tdata[KEY_W-1:0]),
    .rd_data (ram_rd_data)
  );

  sc1kd_decode #(
    .SLOT_W (SLOT_W)
  ) u_decode (
    .kind        (s1_kind),
    .scancode    (s1_code),
    .key_bit_old (key_bit_old),
    .cur         (kstate),
    .capacity    (capacity),
    .slot        (text_slot),
    .slot_last   (SLOT_LAST),
    .res         (res),
    .nxt         (kstate_next),
    .slot_next   (text_slot_next),
    .key_wr      (key_wr),
    .key_bit_new (key_bit_new)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAPACITY_RESET;
      kstate        <= '0;
      text_slot     <= '0;
      key_valid     <= '0;
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      // commit the staged transaction as its result enters the output
      if (s1_advance) begin
        kstate    <= kstate_next;
        text_slot <= text_slot_next;
        if (key_wr) begin
          key_valid[s1_code[KEY_W-1:0]] <= 1'b1;
        end
      end
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload: hold while stalled, load on transaction
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_kind <= s_axis_tuser;
      s1_code <= s_axis_tdata;
      // a staged item can only sit beside a new one while it advances
      fwd_hit <= s1_valid && (s1_kind == KIND_SCAN) &&
                 (s1_code[KEY_W-1:0] == s_axis_tdata[KEY_W-1:0]);
      fwd_val <= key_bit_new;
    end
    if (s1_advance) begin
      m_axis_tdata <= {(TDATA_W - OUT_W)'(0), res};
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted transaction did not reach decode stage");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> m_axis_tvalid)
    else $error("decode stage advanced without output valid");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_code) && $stable(s1_kind))
    else $error("stalled decode stage lost its transaction");

  a_key_marked: assert property (@(posedge clk) disable iff (rst)
    s1_advance && (s1_kind == KIND_SCAN) |=> key_valid[$past(s1_code[KEY_W-1:0])])
    else $error("written key entry not marked valid");

endmodule

`default_nettype wire
